/* rtl/hsvr_pkg.sv */
// Shared constants and types for the HSV to RGB converter.
package hsvr_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Hue sector: which channel holds the value level and which one ramps.
    typedef enum logic [2:0] {
        SEC_RED_GRN_UP  = 3'd0,
        SEC_GRN_RED_DN  = 3'd1,
        SEC_GRN_BLU_UP  = 3'd2,
        SEC_BLU_GRN_DN  = 3'd3,
        SEC_BLU_RED_UP  = 3'd4,
        SEC_RED_BLU_DN  = 3'd5
    } t_sector;

endpackage

/* rtl/hsvr_pix_if.sv */
// Handshake channel carrying one HSV beat.
interface hsvr_pix_if
    import hsvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS-1:0] hue;
    logic [FRAC_BITS:0]   saturation;
    logic [FRAC_BITS:0]   brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

/* rtl/hsvr_rgb_if.sv */
// Handshake channel carrying one RGB beat.
interface hsvr_rgb_if
    import hsvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] red;
    logic [FRAC_BITS:0] green;
    logic [FRAC_BITS:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* rtl/hsv_to_rgb.sv */
// HSV to RGB converter: four register stages, the last is the output register.
// Throughput: one beat per cycle while o_rgb.ready is high; ready runs
// combinationally back from o_rgb.ready through every stage, so an empty
// stage always takes a beat and nothing is lost.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; data is not reset.
module hsv_to_rgb
    import hsvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsvr_pix_if.sink    i_pix,
    hsvr_rgb_if.source  o_rgb
);
    logic                 s1_valid;
    logic                 s1_ready;
    t_sector              s1_sector;
    logic [FRAC_BITS-1:0] s1_frac;
    logic [FRAC_BITS:0]   s1_sat;
    logic [FRAC_BITS:0]   s1_val;

    logic                 s2_valid;
    logic                 s2_ready;
    t_sector              s2_sector;
    logic [FRAC_BITS:0]   s2_val;
    logic [FRAC_BITS:0]   s2_np;
    logic [FRAC_BITS:0]   s2_nq;
    logic [FRAC_BITS:0]   s2_nt;

    logic                 s3_valid;
    logic                 s3_ready;
    t_sector              s3_sector;
    logic [FRAC_BITS:0]   s3_val;
    logic [FRAC_BITS:0]   s3_p;
    logic [FRAC_BITS:0]   s3_q;
    logic [FRAC_BITS:0]   s3_t;

    logic                 r_valid;
    logic [FRAC_BITS:0]   r_red;
    logic [FRAC_BITS:0]   r_green;
    logic [FRAC_BITS:0]   r_blue;
    logic [FRAC_BITS:0]   n_red;
    logic [FRAC_BITS:0]   n_green;
    logic [FRAC_BITS:0]   n_blue;

    hsvr_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_pix.valid),
        .o_ready  (i_pix.ready),
        .i_hue    (i_pix.hue),
        .i_sat    (i_pix.saturation),
        .i_val    (i_pix.brightness),
        .o_valid  (s1_valid),
        .i_ready  (s1_ready),
        .o_sector (s1_sector),
        .o_frac   (s1_frac),
        .o_sat    (s1_sat),
        .o_val    (s1_val)
    );

    hsvr_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .o_ready  (s1_ready),
        .i_sector (s1_sector),
        .i_frac   (s1_frac),
        .i_sat    (s1_sat),
        .i_val    (s1_val),
        .o_valid  (s2_valid),
        .i_ready  (s2_ready),
        .o_sector (s2_sector),
        .o_val    (s2_val),
        .o_np     (s2_np),
        .o_nq     (s2_nq),
        .o_nt     (s2_nt)
    );

    hsvr_level #(.FRAC_BITS(FRAC_BITS)) u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s2_valid),
        .o_ready  (s2_ready),
        .i_sector (s2_sector),
        .i_val    (s2_val),
        .i_np     (s2_np),
        .i_nq     (s2_nq),
        .i_nt     (s2_nt),
        .o_valid  (s3_valid),
        .i_ready  (s3_ready),
        .o_sector (s3_sector),
        .o_val    (s3_val),
        .o_p      (s3_p),
        .o_q      (s3_q),
        .o_t      (s3_t)
    );

    // place the levels on the channels by sector
    always_comb begin
        unique case (s3_sector)
            SEC_RED_GRN_UP: begin
                n_red = s3_val; n_green = s3_t;   n_blue = s3_p;
            end
            SEC_GRN_RED_DN: begin
                n_red = s3_q;   n_green = s3_val; n_blue = s3_p;
            end
            SEC_GRN_BLU_UP: begin
                n_red = s3_p;   n_green = s3_val; n_blue = s3_t;
            end
            SEC_BLU_GRN_DN: begin
                n_red = s3_p;   n_green = s3_q;   n_blue = s3_val;
            end
            SEC_BLU_RED_UP: begin
                n_red = s3_t;   n_green = s3_p;   n_blue = s3_val;
            end
            default: begin
                n_red = s3_val; n_green = s3_p;   n_blue = s3_q;
            end
        endcase
    end

    assign s3_ready = !r_valid || o_rgb.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s3_ready) begin
            r_valid <= s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_rgb.valid = r_valid;
    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_green;
    assign o_rgb.blue  = r_blue;
endmodule

/* rtl/hsvr_prep.sv */
// Stage 1: clamp saturation and value, split hue*6 into sector and fraction.
module hsvr_prep
    import hsvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [FRAC_BITS-1:0] i_hue,
    input  logic [FRAC_BITS:0]   i_sat,
    input  logic [FRAC_BITS:0]   i_val,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_sector              o_sector,
    output logic [FRAC_BITS-1:0] o_frac,
    output logic [FRAC_BITS:0]   o_sat,
    output logic [FRAC_BITS:0]   o_val
);
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic                 r_valid;
    t_sector              r_sector;
    logic [FRAC_BITS-1:0] r_frac;
    logic [FRAC_BITS:0]   r_sat;
    logic [FRAC_BITS:0]   r_val;
    logic [FRAC_BITS+2:0] n_h6;

    // hue*6 as 4h + 2h
    assign n_h6    = (FRAC_BITS+3)'({i_hue, 2'b00}) + (FRAC_BITS+3)'({i_hue, 1'b0});
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_sector <= t_sector'(n_h6[FRAC_BITS+2:FRAC_BITS]);
            r_frac   <= n_h6[FRAC_BITS-1:0];
            r_sat    <= (i_sat > ONE) ? ONE : i_sat;
            r_val    <= (i_val > ONE) ? ONE : i_val;
        end
    end

    assign o_valid  = r_valid;
    assign o_sector = r_sector;
    assign o_frac   = r_frac;
    assign o_sat    = r_sat;
    assign o_val    = r_val;
endmodule

/* rtl/hsvr_ramp.sv */
// Stage 2: form the complements 1-s, 1-s*f and 1-s*(1-f).
module hsvr_ramp
    import hsvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_sector              i_sector,
    input  logic [FRAC_BITS-1:0] i_frac,
    input  logic [FRAC_BITS:0]   i_sat,
    input  logic [FRAC_BITS:0]   i_val,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_sector              o_sector,
    output logic [FRAC_BITS:0]   o_val,
    output logic [FRAC_BITS:0]   o_np,
    output logic [FRAC_BITS:0]   o_nq,
    output logic [FRAC_BITS:0]   o_nt
);
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam int PW = 2*FRAC_BITS + 2;

    logic               r_valid;
    t_sector            r_sector;
    logic [FRAC_BITS:0] r_val;
    logic [FRAC_BITS:0] r_np;
    logic [FRAC_BITS:0] r_nq;
    logic [FRAC_BITS:0] r_nt;
    logic [FRAC_BITS:0] n_inv_f;
    logic [PW-1:0]      n_prod_sf;
    logic [PW-1:0]      n_prod_sg;

    assign n_inv_f   = ONE - {1'b0, i_frac};
    assign n_prod_sf = PW'(i_sat) * PW'({1'b0, i_frac});
    assign n_prod_sg = PW'(i_sat) * PW'(n_inv_f);
    assign o_ready   = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // truncate each product back to FRAC_BITS fraction bits
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_sector <= i_sector;
            r_val    <= i_val;
            r_np     <= ONE - i_sat;
            r_nq     <= ONE - n_prod_sf[2*FRAC_BITS:FRAC_BITS];
            r_nt     <= ONE - n_prod_sg[2*FRAC_BITS:FRAC_BITS];
        end
    end

    assign o_valid  = r_valid;
    assign o_sector = r_sector;
    assign o_val    = r_val;
    assign o_np     = r_np;
    assign o_nq     = r_nq;
    assign o_nt     = r_nt;
endmodule

/* rtl/hsvr_level.sv */
// Stage 3: scale the complements by value to get the p, q and t levels.
module hsvr_level
    import hsvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_sector            i_sector,
    input  logic [FRAC_BITS:0] i_val,
    input  logic [FRAC_BITS:0] i_np,
    input  logic [FRAC_BITS:0] i_nq,
    input  logic [FRAC_BITS:0] i_nt,
    output logic               o_valid,
    input  logic               i_ready,
    output t_sector            o_sector,
    output logic [FRAC_BITS:0] o_val,
    output logic [FRAC_BITS:0] o_p,
    output logic [FRAC_BITS:0] o_q,
    output logic [FRAC_BITS:0] o_t
);
    localparam int PW = 2*FRAC_BITS + 2;

    logic               r_valid;
    t_sector            r_sector;
    logic [FRAC_BITS:0] r_val;
    logic [FRAC_BITS:0] r_p;
    logic [FRAC_BITS:0] r_q;
    logic [FRAC_BITS:0] r_t;
    logic [PW-1:0]      n_prod_p;
    logic [PW-1:0]      n_prod_q;
    logic [PW-1:0]      n_prod_t;

    assign n_prod_p = PW'(i_val) * PW'(i_np);
    assign n_prod_q = PW'(i_val) * PW'(i_nq);
    assign n_prod_t = PW'(i_val) * PW'(i_nt);
    assign o_ready  = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_sector <= i_sector;
            r_val    <= i_val;
            r_p      <= n_prod_p[2*FRAC_BITS:FRAC_BITS];
            r_q      <= n_prod_q[2*FRAC_BITS:FRAC_BITS];
            r_t      <= n_prod_t[2*FRAC_BITS:FRAC_BITS];
        end
    end

    assign o_valid  = r_valid;
    assign o_sector = r_sector;
    assign o_val    = r_val;
    assign o_p      = r_p;
    assign o_q      = r_q;
    assign o_t      = r_t;
endmodule
